FILE: src/dc_position_p_controller_unit_macros.svh
// assertion macros used by the checker file of the position controller
`ifndef DC_POSITION_P_CONTROLLER_UNIT_MACROS_SVH
`define DC_POSITION_P_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk and off during reset
`define DCPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk and off during reset
`define DCPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dcpc_pkg.sv
// types, codes and reset constants of the position controller
`default_nettype none

package dcpc_pkg;

    localparam int POS_W = 32;
    localparam int REG_W = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [REG_W-1:0] KP_RESET        = 16'd200;
    localparam logic [REG_W-1:0] MAX_ERROR_RESET = 16'd327;
    localparam logic [REG_W-1:0] MIN_ERROR_RESET = 16'd2;
    localparam logic [REG_W-1:0] MIN_PWM_RESET   = 16'd9000;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_TARGET_ADD = 3'd1,
        OP_TARGET_SUB = 3'd2,
        OP_ZERO       = 3'd3,
        OP_REPORT     = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP        = 3'd0,
        CFG_MAX_ERROR = 3'd1,
        CFG_MIN_ERROR = 3'd2,
        CFG_MIN_PWM   = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] cw_steps;
        logic [15:0] ccw_steps;
        logic [15:0] target_delta;
        logic [7:0]  zero_request;
    } cmd_item_t;

    typedef struct packed {
        logic [15:0] pwm_duty;
        logic        spin_direction;
        logic        brake;
        logic        report_valid;
        logic        report_direction;
        logic [15:0] report_magnitude;
    } rsp_item_t;

    typedef struct packed {
        logic [REG_W-1:0] kp;
        logic [REG_W-1:0] max_error;
        logic [REG_W-1:0] min_error;
        logic [REG_W-1:0] min_pwm;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic        direction;
        logic [15:0] magnitude;
    } rpt_t;

    // after the state update
    typedef struct packed {
        logic             tick;
        logic             zero_brake;
        logic [POS_W-1:0] err;
        rpt_t             rpt;
    } s1_t;

    // after abs, clamp and deadband test
    typedef struct packed {
        logic             tick;
        logic             zero_brake;
        logic             active;
        logic             neg;
        logic             raise;
        logic [REG_W-1:0] mag;
        rpt_t             rpt;
    } s2_t;

    // after the gain multiply
    typedef struct packed {
        logic               tick;
        logic               zero_brake;
        logic               active;
        logic               neg;
        logic               raise;
        logic [2*REG_W-1:0] prod;
        rpt_t               rpt;
    } s3_t;

    // pipeline load enables from the flow control
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } pipe_ctl_t;

endpackage

`default_nettype wire

FILE: src/dc_position_p_controller_unit.sv
// top level of the encoder-step position p controller with deadband
// path: an accepted item passes the state, clamp and multiply ranks into the result rank
// throughput: one item per cycle unless stalled; five register ranks (input, state, clamp,
//   multiply, result) each hold one item, the 16x16 multiply sets the clock path
// reset: gains return to defaults, error and step totals clear, pipeline empties
`default_nettype none

module dc_position_p_controller_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // command items
    input  wire logic                            cmd_valid,
    output logic                                 cmd_stall,
    input  wire dcpc_pkg::cmd_item_t             cmd,
    // result items
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output dcpc_pkg::rsp_item_t                  rsp,
    // register writes
    input  wire logic                            cfg_write,
    input  wire logic [dcpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dcpc_pkg::REG_W-1:0]      cfg_data
);
    import dcpc_pkg::*;

    // gain and limit registers
    cfg_t      cfg_reg;

    // valid bit of each rank
    logic      v0_reg, v1_reg, v2_reg, v3_reg, vo_reg;
    logic      free0, free1, free2, free3, free_o;
    pipe_ctl_t ctl;

    cmd_item_t cmd_reg;
    s1_t       s1;
    s3_t       s3;
    rsp_item_t rsp_reg, rsp_next;
    logic [REG_W-1:0] duty;

    // config writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp        <= KP_RESET;
            cfg_reg.max_error <= MAX_ERROR_RESET;
            cfg_reg.min_error <= MIN_ERROR_RESET;
            cfg_reg.min_pwm   <= MIN_PWM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_KP:        cfg_reg.kp        <= cfg_data;
                CFG_MAX_ERROR: cfg_reg.max_error <= cfg_data;
                CFG_MIN_ERROR: cfg_reg.min_error <= cfg_data;
                CFG_MIN_PWM:   cfg_reg.min_pwm   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // a rank may load when it is empty or its item moves on; bubbles collapse
    always_comb
    begin
        free_o   = !vo_reg || !rsp_stall;
        free3    = !v3_reg || free_o;
        free2    = !v2_reg || free3;
        free1    = !v1_reg || free2;
        free0    = !v0_reg || free1;
        ctl.ld1  = v0_reg && free1;
        ctl.ld2  = v1_reg && free2;
        ctl.ld3  = v2_reg && free3;
    end

    assign cmd_stall = !free0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (free0)
            begin
                v0_reg <= cmd_valid;
            end
            if (free1)
            begin
                v1_reg <= v0_reg;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                v3_reg <= v2_reg;
            end
            if (free_o)
            begin
                vo_reg <= v3_reg;
            end
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (free0 && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
    end

    // error and totals update, report values
    dcpc_state u_state (
        .clk   (clk),
        .rst_n (rst_n),
        .ld    (ctl.ld1),
        .item  (cmd_reg),
        .s1    (s1)
    );

    // clamp and multiply
    dcpc_law u_law (
        .clk (clk),
        .ld2 (ctl.ld2),
        .ld3 (ctl.ld3),
        .cfg (cfg_reg),
        .s1  (s1),
        .s3  (s3)
    );

    // saturate, floor at min_pwm outside the deadband when max_error exceeds min_error, build the result item
    always_comb
    begin
        duty     = (s3.prod[2*REG_W-1:REG_W] != '0) ? '1 : s3.prod[REG_W-1:0];
        if (duty < cfg_reg.min_pwm && s3.raise)
        begin
            duty = cfg_reg.min_pwm;
        end
        rsp_next = '0;
        if (s3.tick)
        begin
            if (s3.active)
            begin
                rsp_next.pwm_duty       = duty;
                rsp_next.spin_direction = s3.neg;
            end
            else
            begin
                rsp_next.brake = 1'b1;
            end
        end
        else
        begin
            rsp_next.brake = s3.zero_brake;
        end
        rsp_next.report_valid     = s3.rpt.valid;
        rsp_next.report_direction = s3.rpt.direction;
        rsp_next.report_magnitude = s3.rpt.magnitude;
    end

    // result register; holds while stalled
    always_ff @(posedge clk)
    begin
        if (free_o && v3_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = vo_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: src/dcpc_state.sv
// position error and step total state, updated once per item
`default_nettype none

module dcpc_state (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            ld,
    input  wire dcpc_pkg::cmd_item_t item,
    output dcpc_pkg::s1_t        s1
);
    import dcpc_pkg::*;

    // target minus position is kept as one register
    logic [POS_W-1:0] err_reg, err_next;
    logic [15:0]      cw_total_reg, cw_total_next;
    logic [15:0]      ccw_total_reg, ccw_total_next;
    s1_t              s1_reg, s1_next;

    always_comb
    begin
        err_next       = err_reg;
        cw_total_next  = cw_total_reg;
        ccw_total_next = ccw_total_reg;
        s1_next        = '0;
        case (item.operation)
            OP_TICK:
            begin
                s1_next.tick = 1'b1;
                if (item.cw_steps != 16'd0)
                begin
                    err_next      = err_reg - {16'd0, item.cw_steps};
                    cw_total_next = cw_total_reg + item.cw_steps;
                end
                else
                begin
                    err_next       = err_reg + {16'd0, item.ccw_steps};
                    ccw_total_next = ccw_total_reg + item.ccw_steps;
                end
            end
            OP_TARGET_ADD:
            begin
                err_next = err_reg + {16'd0, item.target_delta};
            end
            OP_TARGET_SUB:
            begin
                err_next = err_reg - {16'd0, item.target_delta};
            end
            OP_ZERO:
            begin
                if (item.zero_request != 8'd0)
                begin
                    err_next           = '0;
                    s1_next.zero_brake = 1'b1;
                end
            end
            OP_REPORT:
            begin
                s1_next.rpt.valid = 1'b1;
                if (cw_total_reg > ccw_total_reg)
                begin
                    s1_next.rpt.direction = 1'b0;
                    s1_next.rpt.magnitude = cw_total_reg - ccw_total_reg;
                end
                else
                begin
                    s1_next.rpt.direction = 1'b1;
                    s1_next.rpt.magnitude = ccw_total_reg - cw_total_reg;
                end
                cw_total_next  = '0;
                ccw_total_next = '0;
            end
            default:
            begin
            end
        endcase
        s1_next.err = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg       <= '0;
            cw_total_reg  <= '0;
            ccw_total_reg <= '0;
        end
        else if (ld)
        begin
            err_reg       <= err_next;
            cw_total_reg  <= cw_total_next;
            ccw_total_reg <= ccw_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

`default_nettype wire

FILE: src/dcpc_law.sv
// control law stages: abs and clamp, then gain multiply
`default_nettype none

module dcpc_law (
    input  wire logic            clk,
    input  wire logic            ld2,
    input  wire logic            ld3,
    input  wire dcpc_pkg::cfg_t  cfg,
    input  wire dcpc_pkg::s1_t   s1,
    output dcpc_pkg::s3_t        s3
);
    import dcpc_pkg::*;

    s2_t              s2_reg, s2_next;
    s3_t              s3_reg, s3_next;
    logic [POS_W-1:0] abs_err;

    // stage 2: magnitude, clamp and deadband decisions
    always_comb
    begin
        abs_err            = s1.err[POS_W-1] ? (POS_W'(0) - s1.err) : s1.err;
        s2_next            = '0;
        s2_next.tick       = s1.tick;
        s2_next.zero_brake = s1.zero_brake;
        s2_next.rpt        = s1.rpt;
        s2_next.neg        = s1.err[POS_W-1];
        s2_next.active     = abs_err > {16'd0, cfg.min_error};
        // min(abs, max) > min  <=>  abs > min and max > min
        s2_next.raise      = s2_next.active && (cfg.max_error > cfg.min_error);
        s2_next.mag        = (abs_err > {16'd0, cfg.max_error}) ? cfg.max_error
                                                                 : abs_err[REG_W-1:0];
    end

    // stage 3: one 16x16 multiply
    always_comb
    begin
        s3_next            = '0;
        s3_next.tick       = s2_reg.tick;
        s3_next.zero_brake = s2_reg.zero_brake;
        s3_next.active     = s2_reg.active;
        s3_next.neg        = s2_reg.neg;
        s3_next.raise      = s2_reg.raise;
        s3_next.rpt        = s2_reg.rpt;
        s3_next.prod       = {16'd0, cfg.kp} * {16'd0, s2_reg.mag};
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_reg <= s2_next;
        end
        if (ld3)
        begin
            s3_reg <= s3_next;
        end
    end

    assign s3 = s3_reg;

endmodule

`default_nettype wire

FILE: src/dcpc_checker.sv
// port-level checks on the result channel of the position controller
`default_nettype none

`include "dc_position_p_controller_unit_macros.svh"

module dcpc_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                rsp_valid,
    input wire logic                rsp_stall,
    input wire dcpc_pkg::rsp_item_t rsp
);
    import dcpc_pkg::*;

    // a stalled result item stays put
    `DCPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result item changed")

    // braking never drives the motor
    `DCPC_ASSERT_SAME(a_brake_no_duty, rsp_valid && rsp.brake, rsp.pwm_duty == 16'd0 && !rsp.spin_direction, "brake with nonzero duty or ccw")

    // a report item carries no motor command
    `DCPC_ASSERT_SAME(a_report_quiet, rsp_valid && rsp.report_valid, rsp.pwm_duty == 16'd0 && !rsp.brake && !rsp.spin_direction, "report item with motor fields set")

    // report fields are zero on every other item
    `DCPC_ASSERT_SAME(a_report_clear, rsp_valid && !rsp.report_valid, rsp.report_magnitude == 16'd0 && !rsp.report_direction, "report fields set without report")

endmodule

bind dc_position_p_controller_unit dcpc_checker u_dcpc_checker (.*);

`default_nettype wire
